// ===== rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the permutation pattern search block.
// ----------------------------------------------------------------------------
package pps_pkg;

    // default store capacities
    localparam int MAX_TEXT_DEF    = 16;
    localparam int MAX_PATTERN_DEF = 8;

    // payload widths
    localparam int VALUE_W = 8;
    localparam int FUNC_W  = 2;
    localparam int IN_USER_W  = FUNC_W + 1;   // func, first
    localparam int OUT_DATA_W = 8;            // found, overflow, zero fill

    // operation codes carried in the low bits of the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_TEXT = 2'd0,
        FUNC_LOAD_PAT  = 2'd1,
        FUNC_SEARCH    = 2'd2
    } t_func;

endpackage

// ===== rtl/pps_ram.sv =====
// ----------------------------------------------------------------------------
// pps_ram
// Simple dual-port store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/permutation_pattern_search.sv =====
// ----------------------------------------------------------------------------
// permutation_pattern_search
// Brute-force permutation pattern containment over loaded text and pattern.
// ----------------------------------------------------------------------------
// Load transactions are taken one per cycle, back to back, while idle.
// Once accepted, a search holds s_axis_tready low while it seeds the tuple, then
// fetches each right-hand element, compares each pair, scans slots on advance
// and refills the slots after it. A trivial search (k above n, or k up to 1)
// skips all that. ST_DONE then moves the verdict out, waiting while the output
// is still full. Reset clears counts.
// ----------------------------------------------------------------------------
module permutation_pattern_search #(
    parameter int MAX_TEXT    = pps_pkg::MAX_TEXT_DEF,
    parameter int MAX_PATTERN = pps_pkg::MAX_PATTERN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pps_pkg::VALUE_W-1:0]      s_axis_tdata,   // [7:0] value
    input  logic [pps_pkg::IN_USER_W-1:0]    s_axis_tuser,   // [1:0] func, [2] first
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pps_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // [0] found, [1] overflow
);

    import pps_pkg::*;

    // index and count widths
    localparam int TIDX_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int TC_W   = $clog2(MAX_TEXT + 1);
    localparam int PC_W   = $clog2(MAX_PATTERN + 1);
    localparam int CW     = (TC_W > PC_W) ? TC_W : PC_W;

    // Search sequencer. Element fetches go through registered store reads:
    // CI* fetch the right-hand element i, CJ* the left-hand element j and
    // compare; AV* scan for the rightmost tuple slot with room; FILL packs
    // the slots after it.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CI0,
        ST_CI1,
        ST_CI2,
        ST_CJ0,
        ST_CJ1,
        ST_CJ2,
        ST_AV0,
        ST_AV1,
        ST_FILL,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [TC_W-1:0]     r_txt_cnt;
    logic [PC_W-1:0]     r_pat_cnt;
    logic                r_ovf_txt;
    logic                r_ovf_pat;
    logic [PIDX_W-1:0]   r_i;
    logic [PIDX_W-1:0]   r_j;
    logic [PIDX_W-1:0]   r_a;        // init / advance / fill position
    logic [TC_W-1:0]     r_bound;    // upper limit for slot r_a
    logic [TIDX_W-1:0]   r_val;      // last value written while filling
    logic [VALUE_W-1:0]  r_pi;       // pattern[i]
    logic [VALUE_W-1:0]  r_xi;       // text[tuple[i]]
    logic [VALUE_W-1:0]  r_pj;       // pattern[j]
    logic                r_res;
    logic                r_m_valid;
    logic                r_found;
    logic                r_ovf_out;

    // input decode
    logic                s_hs;
    logic [FUNC_W-1:0]   in_func;
    logic                in_first;
    logic [TC_W-1:0]     txt_base;
    logic [PC_W-1:0]     pat_base;
    logic                txt_room;
    logic                pat_room;

    // store ports
    logic                txt_we;
    logic [TIDX_W-1:0]   txt_raddr;
    logic [VALUE_W-1:0]  txt_q;
    logic                pat_we;
    logic [PIDX_W-1:0]   pat_raddr;
    logic [VALUE_W-1:0]  pat_q;
    logic                tup_we;
    logic [PIDX_W-1:0]   tup_waddr;
    logic [TIDX_W-1:0]   tup_wdata;
    logic [PIDX_W-1:0]   tup_raddr;
    logic [TIDX_W-1:0]   tup_q;

    // shared compare / step unit
    logic                pair_ok;
    logic                j_last;
    logic                i_last;
    logic                a_last;
    logic                adv_room;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_hs          = s_axis_tvalid && s_axis_tready;
    assign in_func       = s_axis_tuser[FUNC_W-1:0];
    assign in_first      = s_axis_tuser[FUNC_W];

    assign txt_base = in_first ? '0 : r_txt_cnt;
    assign pat_base = in_first ? '0 : r_pat_cnt;
    assign txt_room = (txt_base < TC_W'(MAX_TEXT));
    assign pat_room = (pat_base < PC_W'(MAX_PATTERN));

    assign txt_we = s_hs && (in_func == FUNC_LOAD_TEXT) && txt_room;
    assign pat_we = s_hs && (in_func == FUNC_LOAD_PAT) && pat_room;

    // pairwise order check: equal values count as not greater
    assign pair_ok  = ((r_pj > r_pi) == (txt_q > r_xi));
    assign j_last   = ((PC_W'(r_j) + PC_W'(1)) >= PC_W'(r_i));
    assign i_last   = ((PC_W'(r_i) + PC_W'(1)) >= r_pat_cnt);
    assign a_last   = ((PC_W'(r_a) + PC_W'(1)) == r_pat_cnt);
    assign adv_room = ((TC_W'(tup_q) + TC_W'(1)) < r_bound);

    // read address selection
    always_comb begin
        tup_raddr = r_a;
        pat_raddr = r_j;
        case (r_state)
            ST_CI0: begin
                tup_raddr = r_i;
                pat_raddr = r_i;
            end
            ST_CJ0: begin
                tup_raddr = r_j;
                pat_raddr = r_j;
            end
            default: begin
                tup_raddr = r_a;
                pat_raddr = r_j;
            end
        endcase
    end

    assign txt_raddr = tup_q;

    // tuple writes: initial fill, advance step, packing after it
    always_comb begin
        tup_we    = 1'b0;
        tup_waddr = r_a;
        tup_wdata = r_val + TIDX_W'(1);
        case (r_state)
            ST_INIT: begin
                tup_we    = 1'b1;
                tup_wdata = TIDX_W'(r_a);
            end
            ST_AV1: begin
                tup_we    = adv_room;
                tup_wdata = tup_q + TIDX_W'(1);
            end
            ST_FILL: begin
                tup_we    = 1'b1;
            end
            default: begin
                tup_we    = 1'b0;
            end
        endcase
    end

    pps_ram #(
        .DEPTH (MAX_TEXT),
        .WIDTH (VALUE_W),
        .AW    (TIDX_W)
    ) u_txt_ram (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (txt_base[TIDX_W-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (txt_raddr),
        .o_rdata (txt_q)
    );

    pps_ram #(
        .DEPTH (MAX_PATTERN),
        .WIDTH (VALUE_W),
        .AW    (PIDX_W)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (pat_base[PIDX_W-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (pat_raddr),
        .o_rdata (pat_q)
    );

    pps_ram #(
        .DEPTH (MAX_PATTERN),
        .WIDTH (TIDX_W),
        .AW    (PIDX_W)
    ) u_tup_ram (
        .i_clk   (i_clk),
        .i_we    (tup_we),
        .i_waddr (tup_waddr),
        .i_wdata (tup_wdata),
        .i_raddr (tup_raddr),
        .o_rdata (tup_q)
    );

    // sequencer, counts and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_txt_cnt <= '0;
            r_pat_cnt <= '0;
            r_ovf_txt <= 1'b0;
            r_ovf_pat <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            // in ST_DONE the state arm below owns the valid flag
            if (m_axis_tvalid && m_axis_tready && (r_state != ST_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_hs) begin
                        case (in_func)
                            FUNC_LOAD_TEXT: begin
                                if (txt_room) begin
                                    r_txt_cnt <= txt_base + TC_W'(1);
                                    r_ovf_txt <= in_first ? 1'b0 : r_ovf_txt;
                                end else begin
                                    r_txt_cnt <= txt_base;
                                    r_ovf_txt <= 1'b1;
                                end
                            end
                            FUNC_LOAD_PAT: begin
                                if (pat_room) begin
                                    r_pat_cnt <= pat_base + PC_W'(1);
                                    r_ovf_pat <= in_first ? 1'b0 : r_ovf_pat;
                                end else begin
                                    r_pat_cnt <= pat_base;
                                    r_ovf_pat <= 1'b1;
                                end
                            end
                            FUNC_SEARCH: begin
                                r_a <= '0;
                                if (CW'(r_pat_cnt) > CW'(r_txt_cnt)) begin
                                    r_res   <= 1'b0;
                                    r_state <= ST_DONE;
                                end else if (r_pat_cnt <= PC_W'(1)) begin
                                    // empty or single-element pattern
                                    r_res   <= 1'b1;
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state <= ST_INIT;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_INIT: begin
                    if (a_last) begin
                        r_i     <= PIDX_W'(1);
                        r_state <= ST_CI0;
                    end else begin
                        r_a <= r_a + PIDX_W'(1);
                    end
                end
                ST_CI0: begin
                    r_state <= ST_CI1;
                end
                ST_CI1: begin
                    r_pi    <= pat_q;
                    r_state <= ST_CI2;
                end
                ST_CI2: begin
                    r_xi    <= txt_q;
                    r_j     <= '0;
                    r_state <= ST_CJ0;
                end
                ST_CJ0: begin
                    r_state <= ST_CJ1;
                end
                ST_CJ1: begin
                    r_pj    <= pat_q;
                    r_state <= ST_CJ2;
                end
                ST_CJ2: begin
                    if (!pair_ok) begin
                        r_a     <= PIDX_W'(r_pat_cnt - PC_W'(1));
                        r_bound <= r_txt_cnt;
                        r_state <= ST_AV0;
                    end else if (!j_last) begin
                        r_j     <= r_j + PIDX_W'(1);
                        r_state <= ST_CJ0;
                    end else if (!i_last) begin
                        r_i     <= r_i + PIDX_W'(1);
                        r_state <= ST_CI0;
                    end else begin
                        r_res   <= 1'b1;
                        r_state <= ST_DONE;
                    end
                end
                ST_AV0: begin
                    r_state <= ST_AV1;
                end
                ST_AV1: begin
                    if (adv_room) begin
                        r_val <= tup_q + TIDX_W'(1);
                        if (a_last) begin
                            r_i     <= PIDX_W'(1);
                            r_state <= ST_CI0;
                        end else begin
                            r_a     <= r_a + PIDX_W'(1);
                            r_state <= ST_FILL;
                        end
                    end else if (r_a == '0) begin
                        r_res   <= 1'b0;
                        r_state <= ST_DONE;
                    end else begin
                        r_bound <= TC_W'(tup_q);
                        r_a     <= r_a - PIDX_W'(1);
                        r_state <= ST_AV0;
                    end
                end
                ST_FILL: begin
                    r_val <= r_val + TIDX_W'(1);
                    if (a_last) begin
                        r_i     <= PIDX_W'(1);
                        r_state <= ST_CI0;
                    end else begin
                        r_a <= r_a + PIDX_W'(1);
                    end
                end
                ST_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_found   <= r_res;
                        r_ovf_out <= r_ovf_txt || r_ovf_pat;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_ovf_out, r_found};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_search_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_hs && (in_func == FUNC_SEARCH)) |=> !s_axis_tready)
        else $error("search transaction did not hold the block busy");

    a_txt_cnt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_txt_cnt) <= CW'(MAX_TEXT)))
        else $error("text count beyond capacity");

    a_pat_cnt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_pat_cnt) <= CW'(MAX_PATTERN)))
        else $error("pattern count beyond capacity");

    a_pair_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CJ2) |-> (r_j < r_i))
        else $error("pair index order broken");

    a_result_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && (!r_m_valid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("finished search did not present a result");

endmodule
